// ===== rtl/sssf_pkg.sv =====
// Shared types, op codes and the BCD segment table for the seven-segment scanner.
// No dependencies; used by every module under rtl/.
`default_nettype none

package sssf_pkg;

	// item op codes
	localparam logic [2:0] OP_REFRESH = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_TOGGLE  = 3'd2;
	localparam logic [2:0] OP_SET     = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
	localparam logic [1:0] REG_FLASH_FIRST  = 2'd1;
	localparam logic [1:0] REG_FLASH_LAST   = 2'd2;
	localparam logic [1:0] REG_FLASH_PERIOD = 2'd3;

	localparam logic [7:0] DOT_BIT  = 8'h80;
	localparam logic [7:0] SEG_MASK = 8'h7F;

	// configuration as seen by the scan logic
	typedef struct packed {
		logic [3:0]  count;       // clamped digit count
		logic [3:0]  first;
		logic [3:0]  last;
		logic [15:0] period;
		logic        count_wr;    // digit count written this cycle
		logic [3:0]  count_new;   // clamped value being written
		logic        flash_wr;    // any flash register written this cycle
	} cfg_t;

	// segment image of a BCD value, blank for 10..15
	function automatic logic [7:0] bcd_image(input logic [3:0] v);
		logic [7:0] r;
		case (v)
			4'd0: r = 8'h3F;
			4'd1: r = 8'h06;
			4'd2: r = 8'h5B;
			4'd3: r = 8'h4F;
			4'd4: r = 8'h66;
			4'd5: r = 8'h6D;
			4'd6: r = 8'h7D;
			4'd7: r = 8'h07;
			4'd8: r = 8'h7F;
			4'd9: r = 8'h6F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/seven_segment_scan_with_flash.sv =====
// Seven-segment scan controller with digit flashing: top level.
// A refresh item gives its result in the cycle after start is taken.
// Throughput: one item per cycle; busy is always low, and updates are registered.
// Reset (arst_n low): store clear, count 4 (clamped to MAX_DIGITS), flash off, position count-1.
// Results appear on done for one cycle; the receiver cannot stall them.
// Depends on sssf_pkg, sssf_cfg, sssf_store, sssf_scan.
`default_nettype none

module seven_segment_scan_with_flash #(
	parameter int MAX_DIGITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [2:0]  digit_index,
	input  wire logic [3:0]  bcd_value,
	input  wire logic        last_of_write,
	input  wire logic [7:0]  dot_mask,
	// result channel
	output logic             done,
	output logic      [7:0]  segments,
	output logic      [2:0]  digit_select,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// position width; at least one bit for a single-digit display
	localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	sssf_pkg::cfg_t cfg;
	logic           item_en;
	logic [PW-1:0]  rd_idx;
	logic [7:0]     rd_data;

	// every item is taken in the cycle start is high; busy is never raised
	assign busy    = 1'b0;
	assign item_en = start & ~busy;

	sssf_cfg #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// segment bytes; the scan reads the next digit's byte combinationally
	sssf_store #(
		.MAX_DIGITS(MAX_DIGITS),
		.PW        (PW)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_en      (item_en),
		.op           (op),
		.digit_index  (digit_index),
		.bcd_value    (bcd_value),
		.last_of_write(last_of_write),
		.dot_mask     (dot_mask),
		.count        (cfg.count),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data)
	);

	// position advance, flash blanking and the result register
	sssf_scan #(
		.MAX_DIGITS(MAX_DIGITS),
		.PW        (PW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_en     (item_en),
		.op          (op),
		.cfg         (cfg),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data),
		.done        (done),
		.segments    (segments),
		.digit_select(digit_select)
	);

endmodule

`default_nettype wire

// ===== rtl/sssf_cfg.sv =====
// APB register file: digit count and flash range/period.
// Depends on sssf_pkg.
`default_nettype none

module sssf_cfg #(
	parameter int MAX_DIGITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output sssf_pkg::cfg_t         cfg
);

	localparam logic [4:0] MAX5      = 5'(MAX_DIGITS);
	localparam int         RST_COUNT = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;

	logic [3:0]  count_q, count_raw_q, first_q, last_q;
	logic [15:0] period_q;
	logic        wr;
	logic [1:0]  idx;
	logic [3:0]  wval, wclamp;

	// value mod (MAX_DIGITS+1) via a 16-entry table
	function automatic logic [3:0] reduce(input logic [3:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (v == 4'(i))
				r = 4'(i % (MAX_DIGITS + 1));
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign wval   = pwdata[3:0];

	always_comb begin
		if (wval == 4'd0)
			wclamp = 4'd1;
		else if ({1'b0, wval} > MAX5)
			wclamp = 4'(MAX_DIGITS);
		else
			wclamp = wval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_raw_q <= 4'd4;
			count_q     <= 4'(RST_COUNT);
			first_q     <= '0;
			last_q      <= '0;
			period_q    <= '0;
		end else if (wr) begin
			case (idx)
				sssf_pkg::REG_DIGIT_COUNT: begin
					count_raw_q <= wval;
					count_q     <= wclamp;
				end
				sssf_pkg::REG_FLASH_FIRST:  first_q  <= reduce(wval);
				sssf_pkg::REG_FLASH_LAST:   last_q   <= reduce(wval);
				sssf_pkg::REG_FLASH_PERIOD: period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sssf_pkg::REG_DIGIT_COUNT:  prdata = {28'd0, count_raw_q};
			sssf_pkg::REG_FLASH_FIRST:  prdata = {28'd0, first_q};
			sssf_pkg::REG_FLASH_LAST:   prdata = {28'd0, last_q};
			sssf_pkg::REG_FLASH_PERIOD: prdata = {16'd0, period_q};
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.count     = count_q;
		cfg.first     = first_q;
		cfg.last      = last_q;
		cfg.period    = period_q;
		cfg.count_wr  = wr && (idx == sssf_pkg::REG_DIGIT_COUNT);
		cfg.count_new = wclamp;
		cfg.flash_wr  = wr && (idx != sssf_pkg::REG_DIGIT_COUNT);
	end

endmodule

`default_nettype wire

// ===== rtl/sssf_store.sv =====
// Per-digit segment byte store (dot in bit 7) with write, dot and blanking updates.
// Depends on sssf_pkg.
`default_nettype none

module sssf_store #(
	parameter int MAX_DIGITS = 8,
	parameter int PW         = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_en,
	input  wire logic [2:0]    op,
	input  wire logic [2:0]    digit_index,
	input  wire logic [3:0]    bcd_value,
	input  wire logic          last_of_write,
	input  wire logic [7:0]    dot_mask,
	input  wire logic [3:0]    count,
	input  wire logic [PW-1:0] rd_idx,
	output logic      [7:0]    rd_data
);

	logic [7:0] store_q [MAX_DIGITS];
	logic [4:0] idx5;
	logic [7:0] img;

	assign idx5    = {2'b00, digit_index};
	assign img     = sssf_pkg::bcd_image(bcd_value);
	assign rd_data = store_q[rd_idx];

	for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
		localparam logic [4:0] G5 = 5'(g);
		logic [7:0] nxt;
		logic       mbit;

		// mask only reaches the first eight digits
		if (g < 8) begin : g_m
			assign mbit = dot_mask[g];
		end else begin : g_nm
			assign mbit = 1'b0;
		end

		always_comb begin
			nxt = store_q[g];
			case (op)
				sssf_pkg::OP_WRITE: begin
					if (idx5 == G5 && idx5 < {1'b0, count})
						nxt = (store_q[g] & sssf_pkg::DOT_BIT) | img;
					if (last_of_write && G5 > idx5)
						nxt = store_q[g] & sssf_pkg::DOT_BIT;
				end
				sssf_pkg::OP_TOGGLE: begin
					if (idx5 == G5)
						nxt = store_q[g] ^ sssf_pkg::DOT_BIT;
				end
				sssf_pkg::OP_SET: begin
					if (mbit)
						nxt = store_q[g] | sssf_pkg::DOT_BIT;
				end
				sssf_pkg::OP_CLEAR: begin
					if (mbit)
						nxt = store_q[g] & sssf_pkg::SEG_MASK;
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				store_q[g] <= '0;
			else if (item_en)
				store_q[g] <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sssf_scan.sv =====
// Scan position, flash counter and the registered refresh result.
// Depends on sssf_pkg.
`default_nettype none

module sssf_scan #(
	parameter int MAX_DIGITS = 8,
	parameter int PW         = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_en,
	input  wire logic [2:0]     op,
	input  wire sssf_pkg::cfg_t cfg,
	output logic      [PW-1:0]  rd_idx,
	input  wire logic [7:0]     rd_data,
	output logic                done,
	output logic      [7:0]     segments,
	output logic      [2:0]     digit_select
);

	localparam int RST_POS = ((MAX_DIGITS < 4) ? MAX_DIGITS : 4) - 1;

	logic [PW-1:0] pos_q, pos_nxt;
	logic [15:0]   fcnt_q, fcnt_nxt;
	logic [4:0]    pos_inc, pos5;
	logic          refresh, blank;
	logic          done_q;
	logic [7:0]    seg_q;
	logic [2:0]    sel_q;

	assign refresh = item_en && (op == sssf_pkg::OP_REFRESH);
	assign pos_inc = 5'(pos_q) + 5'd1;
	assign pos_nxt = (pos_inc >= {1'b0, cfg.count}) ? '0 : PW'(pos_inc);
	assign pos5    = 5'(pos_nxt);
	assign rd_idx  = pos_nxt;

	// counter stays below the period, so the wrap is one compare
	always_comb begin
		fcnt_nxt = fcnt_q;
		if (cfg.period != 16'd0 && pos_nxt == '0)
			fcnt_nxt = (fcnt_q + 16'd1 == cfg.period) ? 16'd0 : fcnt_q + 16'd1;
	end

	assign blank = (cfg.period != 16'd0) && (pos5 >= {1'b0, cfg.first}) &&
		(pos5 <= {1'b0, cfg.last}) && (fcnt_nxt > (cfg.period >> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PW'(RST_POS);
			fcnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= refresh;
			if (cfg.count_wr)
				pos_q <= PW'(cfg.count_new - 4'd1);
			else if (refresh)
				pos_q <= pos_nxt;
			if (cfg.flash_wr)
				fcnt_q <= '0;
			else if (refresh)
				fcnt_q <= fcnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (refresh) begin
			seg_q <= blank ? 8'h00 : rd_data;
			sel_q <= 3'(pos_nxt);
		end
	end

	assign done         = done_q;
	assign segments     = seg_q;
	assign digit_select = sel_q;

endmodule

`default_nettype wire
